>>> sv/stef_pkg.sv
// Shared types and constants for the spanning tree edge filter.
// No dependencies; imported by the engine, the output register and the top level.
package stef_pkg;

    localparam int IDX_W     = 10;
    localparam int MAX_WORDS = 1 << IDX_W;
    localparam int WC_W      = IDX_W + 1;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_WORDS - 1);
    localparam logic [IDX_W-1:0] COUNT_MAX = IDX_W'(MAX_WORDS - 1);
    localparam logic [WC_W-1:0]  WC_RESET  = WC_W'(MAX_WORDS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_CMP,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } stef_state_t;

    typedef struct packed {
        logic             keep;
        logic             bad_index;
        logic [IDX_W-1:0] kept_total;
        logic             tree_complete;
        logic             last;
    } stef_result_t;

endpackage

>>> sv/stef_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module stef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/stef_engine.sv
// Label engine: sequencer, component label memory, kept-edge count.
// Depends on stef_pkg and stef_ram.
module stef_engine
    import stef_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [IDX_W-1:0]  word_a,
    input  logic [IDX_W-1:0]  word_b,
    input  logic              final_edge,
    input  logic [WC_W-1:0]   word_count,
    output logic              res_valid,
    input  logic              res_stall,
    output stef_result_t      res
);

    stef_state_t      state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] a_reg, b_reg, la_reg, lb_reg;
    logic             fin_reg, bad_reg, keep_reg;
    logic [IDX_W-1:0] kept_reg;
    logic             pv_reg;
    logic [IDX_W-1:0] pv_addr_reg;

    logic             accept;
    logic             bad_in;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, wr_data, rd_addr, rd_data;

    assign accept = in_valid && !in_stall;
    // word_count at or above the memory depth never flags an index
    assign bad_in = ({1'b0, word_a} >= word_count) || ({1'b0, word_b} >= word_count);

    stef_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_WORDS)
    ) u_label_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (cnt_reg == IDX_LAST) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bad_in ? ST_FINISH : ST_RD_A;
                end
            end
            ST_RD_A:   state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_CMP;
            ST_CMP:    state_next = (rd_data == la_reg) ? ST_FINISH : ST_WALK;
            ST_WALK:   if (cnt_reg == IDX_LAST) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!res_stall)
                begin
                    state_next = fin_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    // outputs and memory port control
    always_comb
    begin
        in_stall  = 1'b1;
        res_valid = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = cnt_reg;
        wr_en     = 1'b0;
        wr_addr   = pv_addr_reg;
        wr_data   = la_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = cnt_reg;
            end
            ST_IDLE:   in_stall = 1'b0;
            ST_RD_A:
            begin
                rd_en   = 1'b1;
                rd_addr = a_reg;
            end
            ST_RD_B:
            begin
                rd_en   = 1'b1;
                rd_addr = b_reg;
            end
            ST_WALK:
            begin
                rd_en = 1'b1;
                wr_en = pv_reg && (rd_data == lb_reg);
            end
            ST_DRAIN:  wr_en = pv_reg && (rd_data == lb_reg);
            ST_FINISH: res_valid = !res_stall;
            default:   in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        cnt_next = '0;
        if (state_reg == ST_CLEAR || state_reg == ST_WALK)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign res.keep          = keep_reg;
    assign res.bad_index     = bad_reg;
    assign res.kept_total    = kept_reg;
    assign res.tree_complete = fin_reg && (word_count != '0)
                               && ({1'b0, kept_reg} == word_count - 1'b1);
    assign res.last          = fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            kept_reg  <= '0;
            keep_reg  <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= (state_reg == ST_WALK);
            if (accept)
            begin
                keep_reg <= 1'b0;
            end
            if (state_reg == ST_CMP && rd_data != la_reg)
            begin
                keep_reg <= 1'b1;
                if (kept_reg < COUNT_MAX)
                begin
                    kept_reg <= kept_reg + 1'b1;
                end
            end
            if (state_reg == ST_FINISH && !res_stall && fin_reg)
            begin
                kept_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pv_addr_reg <= cnt_reg;
        if (accept)
        begin
            a_reg   <= word_a;
            b_reg   <= word_b;
            fin_reg <= final_edge;
            bad_reg <= bad_in;
        end
        if (state_reg == ST_RD_B)
        begin
            la_reg <= rd_data;
        end
        if (state_reg == ST_CMP)
        begin
            lb_reg <= rd_data;
        end
    end

endmodule

>>> sv/stef_out_reg.sv
// Output register holding one result word for the downstream side.
// Depends on stef_pkg.
module stef_out_reg
    import stef_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  stef_result_t     res,
    output logic             res_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output stef_result_t     out_res
);

    logic         valid_reg;
    stef_result_t data_reg;

    assign res_stall = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_res   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

>>> sv/spanning_tree_edge_filter.sv
// Top level of the spanning tree edge filter: config register, engine, output register.
// Depends on stef_pkg, stef_engine, stef_out_reg.
//
// Kruskal-style edge filter. Edges arrive sorted by falling score, one word per
// handshake; each result word says whether the edge joined two components (keep),
// whether an endpoint was out of range (bad_index), the running kept count, and,
// on the word marked final, whether the kept count equals word_count - 1.
// Component labels live in a 1024 x 10 synchronous RAM. An out-of-range edge goes
// straight to the finish state, a dropped edge reads and compares both labels, and
// a kept edge also walks all 1024 labels through the RAM, one read-modify-write per
// cycle. After the final edge, and after reset, a clearing pass rewrites every label
// to its own index; no input is taken while it runs. A finished result waits in the
// output register, so the next edge can be taken while downstream stalls. The user
// must write word_count through cfg_we / cfg_wdata only while the block is idle;
// the block does not enforce it. Values above 1024 flag no index but never give tree_complete.
module spanning_tree_edge_filter
    import stef_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [WC_W-1:0]   cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [IDX_W-1:0]  word_a,
    input  logic [IDX_W-1:0]  word_b,
    input  logic              final_edge,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              keep,
    output logic              bad_index,
    output logic [IDX_W-1:0]  kept_total,
    output logic              tree_complete,
    output logic              last
);

    logic [WC_W-1:0] word_count_reg;
    logic            res_valid;
    logic            res_stall;
    stef_result_t    res;
    stef_result_t    out_res;

    // word count register, reset to the full memory depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= WC_RESET;
        end
        else if (cfg_we)
        begin
            word_count_reg <= cfg_wdata;
        end
    end

    // sequencer + label RAM
    stef_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .word_a     (word_a),
        .word_b     (word_b),
        .final_edge (final_edge),
        .word_count (word_count_reg),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    // result word buffer toward downstream
    stef_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_stall (res_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign keep          = out_res.keep;
    assign bad_index     = out_res.bad_index;
    assign kept_total    = out_res.kept_total;
    assign tree_complete = out_res.tree_complete;
    assign last          = out_res.last;

    // one edge at a time: the input is stalled in the cycle after a word is accepted
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted on consecutive cycles");

    a_keep_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(keep && bad_index))
        else $error("edge both kept and flagged bad");

    a_complete_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tree_complete) |-> last)
        else $error("tree_complete on a non-final word");

    a_keep_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && keep) |-> (kept_total != '0))
        else $error("kept edge with zero kept_total");

endmodule
